FILE: design/dqp_pkg.sv
// Shared types and constants for the DNS question parser.
`timescale 1ns / 1ps
package dqp_pkg;

  // Field widths
  localparam int LIMIT_W      = 11;
  localparam int BYTE_W       = 8;
  localparam int ID_W         = 16;
  localparam int QTYPE_W      = 16;
  localparam int STATUS_W     = 3;
  localparam int LABEL_W      = 6;
  localparam int POS_W        = 4;
  localparam int OUT_DATA_W   = 48;
  localparam int OUT_FIELDS_W = BYTE_W + ID_W + QTYPE_W + STATUS_W;

  localparam int HEADER_LEN       = 12;
  localparam int NAME_LIMIT_RESET = 256;
  localparam int NAME_LIMIT_MAX_D = 1024;

  // Queue between parser and output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Characters and label bits
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;
  localparam logic [BYTE_W-1:0] CASE_DELTA = 8'd32;
  localparam logic [BYTE_W-1:0] LABEL_FLAG_MASK = 8'hC0;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LEN    = 3'd1,
    PH_BODY   = 3'd2,
    PH_QT_HI  = 3'd3,
    PH_QT_LO  = 3'd4,
    PH_QC_HI  = 3'd5,
    PH_QC_LO  = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_TRUNCATED  = 3'd1,
    ST_NO_QUESTION = 3'd2,
    ST_COMPRESSED = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_t;

  typedef enum logic {
    KIND_CHAR    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  // One queue entry: an optional name character, then an optional summary
  typedef struct packed {
    logic                has_char;
    logic [BYTE_W-1:0]   name_char;
    logic                has_sum;
    logic [ID_W-1:0]     msg_id;
    logic [QTYPE_W-1:0]  query_type;
    status_t             status;
  } entry_t;

  // Lower-case an ASCII letter
  function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) r = c + CASE_DELTA;
    return r;
  endfunction

endpackage

FILE: design/dqp_front.sv
// Parser front end: walks header and question, emits per-byte entries.
`timescale 1ns / 1ps
module dqp_front import dqp_pkg::*; #(
  parameter int NAME_LIMIT_MAX = NAME_LIMIT_MAX_D
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic               in_last,
  input  logic               q_full,
  output logic               push,
  output entry_t             push_entry
);

  logic [LIMIT_W-1:0] name_limit;
  logic [LIMIT_W-1:0] lim;

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [LABEL_W-1:0] left, left_next;
  logic [LIMIT_W-1:0] name_len, name_len_next;
  logic [ID_W-1:0]    id, id_next;
  logic [QTYPE_W-1:0] qtype, qtype_next;
  logic [BYTE_W-1:0]  cnt, cnt_next;
  logic               sent, sent_next;

  logic               accept;
  logic [LIMIT_W:0]   len_plus1;
  logic               has_char;
  logic [BYTE_W-1:0]  ch;
  logic               ph_sum;
  status_t            ph_status;
  logic               eom_sum;
  status_t            sum_status;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Effective limit, clamped to the build maximum
  assign lim = ({21'd0, name_limit} > 32'(NAME_LIMIT_MAX)) ?
               LIMIT_W'(NAME_LIMIT_MAX) : name_limit;
  assign len_plus1 = {1'b0, name_len} + 1'b1;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      name_limit <= LIMIT_W'(NAME_LIMIT_RESET);
    end else if (cfg_wr_en) begin
      name_limit <= cfg_wr_data;
    end
  end

  // Per-byte parse step
  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    left_next     = left;
    name_len_next = name_len;
    id_next       = id;
    qtype_next    = qtype;
    cnt_next      = cnt;
    sent_next     = sent;
    has_char      = 1'b0;
    ch            = '0;
    ph_sum        = 1'b0;
    ph_status     = ST_OK;

    case (phase)
      PH_HEADER: begin
        if (pos == POS_W'(0))      id_next  = {in_byte, 8'h00};
        else if (pos == POS_W'(1)) id_next  = id | {8'h00, in_byte};
        else if (pos == POS_W'(4)) cnt_next = in_byte;
        else if (pos == POS_W'(5)) cnt_next = cnt | in_byte;
        pos_next = pos + 1'b1;
        if (pos_next >= POS_W'(HEADER_LEN)) begin
          if (cnt_next == '0) begin
            ph_sum    = 1'b1;
            ph_status = ST_NO_QUESTION;
          end else begin
            phase_next = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        if (in_byte == '0) begin
          if (name_len >= lim) begin
            ph_sum    = 1'b1;
            ph_status = ST_TOO_LONG;
          end else begin
            phase_next = PH_QT_HI;
          end
        end else if ((in_byte & LABEL_FLAG_MASK) != '0) begin
          ph_sum    = 1'b1;
          ph_status = ST_COMPRESSED;
        end else if (name_len != '0 && len_plus1 >= {1'b0, lim}) begin
          ph_sum    = 1'b1;
          ph_status = ST_TOO_LONG;
        end else begin
          if (name_len != '0) begin
            has_char      = 1'b1;
            ch            = CH_DOT;
            name_len_next = len_plus1[LIMIT_W-1:0];
          end
          left_next  = in_byte[LABEL_W-1:0];
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        if (len_plus1 >= {1'b0, lim}) begin
          ph_sum    = 1'b1;
          ph_status = ST_TOO_LONG;
        end else begin
          has_char      = 1'b1;
          ch            = to_lower(in_byte);
          name_len_next = len_plus1[LIMIT_W-1:0];
          left_next     = left - 1'b1;
          if (left_next == '0) phase_next = PH_LEN;
        end
      end
      PH_QT_HI: begin
        qtype_next = {in_byte, 8'h00};
        phase_next = PH_QT_LO;
      end
      PH_QT_LO: begin
        qtype_next = qtype | {8'h00, in_byte};
        phase_next = PH_QC_HI;
      end
      PH_QC_HI: phase_next = PH_QC_LO;
      PH_QC_LO: begin
        ph_sum    = 1'b1;
        ph_status = ST_OK;
      end
      default: ;
    endcase

    if (ph_sum) begin
      phase_next = PH_DONE;
      sent_next  = 1'b1;
    end

    // Final byte with no summary yet: report truncation
    eom_sum    = in_last && !sent && !ph_sum;
    sum_status = eom_sum ? ST_TRUNCATED : ph_status;

    push_entry.has_char   = has_char;
    push_entry.name_char  = ch;
    push_entry.has_sum    = ph_sum || eom_sum;
    push_entry.msg_id     = id_next;
    push_entry.query_type = (sum_status == ST_OK) ? qtype_next : '0;
    push_entry.status     = sum_status;

    // Message ends: back to header state
    if (in_last) begin
      phase_next    = PH_HEADER;
      pos_next      = '0;
      left_next     = '0;
      name_len_next = '0;
      id_next       = '0;
      qtype_next    = '0;
      cnt_next      = '0;
      sent_next     = 1'b0;
    end
  end

  assign push = accept && (push_entry.has_char || push_entry.has_sum);

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      pos      <= '0;
      left     <= '0;
      name_len <= '0;
      id       <= '0;
      qtype    <= '0;
      cnt      <= '0;
      sent     <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      pos      <= pos_next;
      left     <= left_next;
      name_len <= name_len_next;
      id       <= id_next;
      qtype    <= qtype_next;
      cnt      <= cnt_next;
      sent     <= sent_next;
    end
  end

endmodule

FILE: design/dqp_queue.sv
// Small entry queue decoupling the parser from the output stage.
`timescale 1ns / 1ps
module dqp_queue import dqp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t head
);

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

FILE: design/dqp_back.sv
// Output stage: expands queue entries into result words.
`timescale 1ns / 1ps
module dqp_back import dqp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  empty,
  input  entry_t                head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_kind,
  output logic                  out_last
);

  logic                    char_done, char_done_next;
  logic                    load;
  logic                    split;
  logic                    send_sum;
  logic [OUT_FIELDS_W-1:0] fields;

  // Output register takes a new word whenever it is empty or being drained
  assign load  = !empty && (!out_valid || out_ready);
  // Entry with both a character and a summary takes two words
  assign split = head.has_char && head.has_sum && !char_done;
  assign send_sum = head.has_sum && (char_done || !head.has_char);
  assign pop   = load && !split;

  always_comb begin
    char_done_next = char_done;
    if (load) char_done_next = split;
    if (send_sum) begin
      fields = {head.status, head.query_type, head.msg_id, {BYTE_W{1'b0}}};
    end else begin
      fields = {{(OUT_FIELDS_W-BYTE_W){1'b0}}, head.name_char};
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      char_done <= 1'b0;
    end else begin
      char_done <= char_done_next;
      if (load)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, fields};
      out_kind <= send_sum ? KIND_SUMMARY : KIND_CHAR;
      out_last <= !split;
    end
  end

endmodule

FILE: design/dns_question_parser_top.sv
// Top level of the DNS question parser.
//
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready         tdata[7:0] msg_byte, tlast end_of_message
//  m_axis    out  tvalid/tready         tdata name_char..status, tuser kind, tlast
//  cfg       in   cfg_wr_en             cfg_wr_data name_limit
//
// One message byte is taken per cycle while the entry queue has room.
// A byte that yields a name character and a truncation summary produces two
// output words; every other byte yields at most one word.
// Each entry is registered in the queue, then in the output word register.
// Output stalls back up into the four-entry queue, then into s_axis_tready.
// Reset is synchronous; name_limit returns to 256.
`timescale 1ns / 1ps
module dns_question_parser_top import dqp_pkg::*; #(
  parameter int NAME_LIMIT_MAX = NAME_LIMIT_MAX_D
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [LIMIT_W-1:0]    cfg_wr_data,     // name_limit
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,    // [7:0] msg_byte
  input  logic                  s_axis_tlast,    // end_of_message
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] name_char, [23:8] msg_id, [39:24] query_type, [42:40] status
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,    // result_kind
  output logic                  m_axis_tlast     // last_of_run
);

  logic   q_full;
  logic   q_empty;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head;

  dqp_front #(
    .NAME_LIMIT_MAX(NAME_LIMIT_MAX)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  dqp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  dqp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (q_empty),
    .head     (head),
    .pop      (pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_kind (m_axis_tuser),
    .out_last (m_axis_tlast)
  );

  // Character words carry nothing above the character
  a_char_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_CHAR |-> m_axis_tdata[OUT_DATA_W-1:BYTE_W] == '0)
    else $error("character word carries summary bits");

  // A summary always closes the run of its byte
  a_sum_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_SUMMARY |-> m_axis_tlast)
    else $error("summary word without tlast");

  // Failed parses report no query type
  a_err_qtype: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_SUMMARY && m_axis_tdata[42:40] != ST_OK
      |-> m_axis_tdata[39:24] == '0)
    else $error("query type on failed summary");

  // Queue never pushed while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("push into full queue");

endmodule

FILE: test/dns_question_parser_check.sv
// Checker for the DNS question parser: predicts every output word and compares it.
`timescale 1ns / 1ps
module dns_question_parser_check import dqp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [LIMIT_W-1:0]    cfg_wr_data,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,     // [7:0] msg_byte
  input  logic                  s_axis_tlast,     // end_of_message
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] name_char, [23:8] msg_id, [39:24] query_type, [42:40] status
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tuser,     // result_kind
  input  logic                  m_axis_tlast,     // last_of_run
  output int                    errors,
  output int                    pending,
  output int                    chars_seen,
  output int                    summaries_seen,
  output logic [4:0]            status_mask       // one bit per status code
);

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  name_char;
    logic [ID_W-1:0]    msg_id;
    logic [QTYPE_W-1:0] query_type;
    status_t            status;
    logic               last;
  } out_word_t;

  // Words predicted but not yet seen on m_axis, oldest first
  out_word_t expected_words[$];

  // Predictor state, one message at a time
  logic [LIMIT_W-1:0] name_limit;
  int                 header_pos;
  phase_t             phase;
  logic [LABEL_W-1:0] label_left;
  int                 name_len;
  logic [ID_W-1:0]    cur_id;
  logic [QTYPE_W-1:0] cur_qtype;
  logic [BYTE_W-1:0]  qdcount_or;
  logic               summary_done;

  task automatic start_message();
    header_pos   = 0;
    phase        = PH_HEADER;
    label_left   = '0;
    name_len     = 0;
    cur_id       = '0;
    cur_qtype    = '0;
    qdcount_or   = '0;
    summary_done = 1'b0;
  endtask

  task automatic push_char(input logic [BYTE_W-1:0] ch);
    out_word_t w;
    w           = '0;
    w.kind      = KIND_CHAR;
    w.name_char = ch;
    expected_words.push_back(w);
  endtask

  // Summary ends the parse; later bytes are ignored until end of message
  task automatic push_summary(input status_t st);
    out_word_t w;
    w            = '0;
    w.kind       = KIND_SUMMARY;
    w.msg_id     = cur_id;
    w.query_type = (st == ST_OK) ? cur_qtype : '0;
    w.status     = st;
    expected_words.push_back(w);
    summary_done = 1'b1;
    phase        = PH_DONE;
  endtask

  // Advance the parse by one message byte and queue the words it causes
  task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic eom);
    int                lim;
    int                first;
    logic [BYTE_W-1:0] c;
    out_word_t         w;
    lim   = (name_limit > NAME_LIMIT_MAX_D) ? NAME_LIMIT_MAX_D : int'(name_limit);
    first = expected_words.size();
    case (phase)
      PH_HEADER: begin
        case (header_pos)
          0: cur_id = {b, 8'h00};
          1: cur_id = cur_id | {8'h00, b};
          4: qdcount_or = b;
          5: qdcount_or = qdcount_or | b;
          default: ;
        endcase
        header_pos++;
        if (header_pos >= HEADER_LEN) begin
          if (qdcount_or == '0) push_summary(ST_NO_QUESTION);
          else phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b == '0) begin
          if (name_len >= lim) push_summary(ST_TOO_LONG);
          else phase = PH_QT_HI;
        end else if ((b & LABEL_FLAG_MASK) != '0) begin
          push_summary(ST_COMPRESSED);
        end else if (name_len != 0 && name_len + 1 >= lim) begin
          // no room for the separating dot
          push_summary(ST_TOO_LONG);
        end else begin
          if (name_len != 0) begin
            push_char(CH_DOT);
            name_len++;
          end
          label_left = b[LABEL_W-1:0];
          phase      = PH_BODY;
        end
      end
      PH_BODY: begin
        if (name_len + 1 >= lim) begin
          push_summary(ST_TOO_LONG);
        end else begin
          c = b;
          if (c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + CASE_DELTA;
          push_char(c);
          name_len++;
          label_left = label_left - 1'b1;
          if (label_left == '0) phase = PH_LEN;
        end
      end
      PH_QT_HI: begin
        cur_qtype = {b, 8'h00};
        phase     = PH_QT_LO;
      end
      PH_QT_LO: begin
        cur_qtype = cur_qtype | {8'h00, b};
        phase     = PH_QC_HI;
      end
      PH_QC_HI: phase = PH_QC_LO;
      PH_QC_LO: push_summary(ST_OK);
      default: ;
    endcase
    // final byte before any summary means the message was cut short
    if (eom) begin
      if (!summary_done) push_summary(ST_TRUNCATED);
      start_message();
    end
    if (expected_words.size() > first) begin
      w      = expected_words.pop_back();
      w.last = 1'b1;
      expected_words.push_back(w);
    end
  endtask

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
    end
  endfunction

  task automatic check_word();
    out_word_t w;
    if (expected_words.size() == 0) begin
      $error("output word with nothing expected: tdata 0x%0h tuser %b tlast %b",
             m_axis_tdata, m_axis_tuser, m_axis_tlast);
      errors++;
    end else begin
      w = expected_words.pop_front();
      compare_field("result_kind", 32'(w.kind), 32'(m_axis_tuser));
      compare_field("name_char", 32'(w.name_char), 32'(m_axis_tdata[7:0]));
      compare_field("msg_id", 32'(w.msg_id), 32'(m_axis_tdata[23:8]));
      compare_field("query_type", 32'(w.query_type), 32'(m_axis_tdata[39:24]));
      compare_field("status", 32'(w.status), 32'(m_axis_tdata[42:40]));
      compare_field("last_of_run", 32'(w.last), 32'(m_axis_tlast));
      if (w.kind == KIND_SUMMARY) begin
        summaries_seen++;
        status_mask[w.status] = 1'b1;
      end else begin
        chars_seen++;
      end
    end
  endtask

  // Input words are predicted before output words are checked in the same cycle
  always @(posedge clk) begin
    if (rst) begin
      expected_words.delete();
      name_limit     = LIMIT_W'(NAME_LIMIT_RESET);
      start_message();
      errors         = 0;
      chars_seen     = 0;
      summaries_seen = 0;
      status_mask    = '0;
    end else begin
      if (cfg_wr_en) name_limit = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_word();
    end
    pending = expected_words.size();
  end

endmodule

FILE: test/dns_question_parser_top_test.sv
// Testbench top for the DNS question parser: message stimulus, output stalls, verdict.
`timescale 1ns / 1ps
module dns_question_parser_top_test;
  import dqp_pkg::*;

  typedef enum int {
    MSG_GOOD,
    MSG_ROOT,
    MSG_TRUNC,
    MSG_NO_QD,
    MSG_COMPRESS,
    MSG_LONG_LABELS,
    MSG_NOISE
  } msg_shape_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } stall_mode_t;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 4;
  localparam int LONG_HOLD     = 120;
  localparam int BIG_LABELS    = 1;
  localparam int MAX_LABEL     = 63;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_wr_en     = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wr_data   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic [BYTE_W-1:0]     s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tready = 1'b0;
  wire                   s_axis_tready;
  wire                   m_axis_tvalid;
  wire  [OUT_DATA_W-1:0] m_axis_tdata;
  wire                   m_axis_tuser;
  wire                   m_axis_tlast;

  int          errors;
  int          pending;
  int          chars_seen;
  int          summaries_seen;
  logic [4:0]  status_mask;

  logic [BYTE_W-1:0] msg_bytes[$];
  int          bytes_sent    = 0;
  int          messages_sent = 0;
  int          limits_used   = 0;
  int          burst_left    = 0;
  int          hold_requests = 0;
  int          holds_served;
  int          hold_left;
  int          mode_left;
  stall_mode_t rx_mode;
  int          cycle_count   = 0;

  dns_question_parser_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  dns_question_parser_check u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .errors         (errors),
    .pending        (pending),
    .chars_seen     (chars_seen),
    .summaries_seen (summaries_seen),
    .status_mask    (status_mask)
  );

  initial forever #1 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
      $display("FAIL");
      $finish;
    end
  end

  // Output side: changing stall patterns, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      holds_served  <= 0;
      mode_left     <= 0;
      rx_mode       <= RX_OPEN;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      m_axis_tready <= 1'b0;
      hold_left     <= LONG_HOLD;
      holds_served  <= holds_served + 1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= stall_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= mode_left[2];
      endcase
    end
  end

  // One word on s_axis; the sender runs in bursts with random gaps
  task automatic send_byte(input logic [BYTE_W-1:0] value, input logic eom);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= eom;
    // ready is stable at the falling edge, so it decides the next rising edge
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    messages_sent++;
  endtask

  task automatic push_random(input int count);
    logic [BYTE_W-1:0] r;
    repeat (count) begin
      r = BYTE_W'($urandom_range(0, 255));
      msg_bytes.push_back(r);
    end
  endtask

  // ID, random flags, QDCOUNT, random answer/authority/additional counts
  task automatic push_header(input logic [ID_W-1:0] id, input logic [15:0] qdcount);
    msg_bytes.push_back(id[15:8]);
    msg_bytes.push_back(id[7:0]);
    push_random(2);
    msg_bytes.push_back(qdcount[15:8]);
    msg_bytes.push_back(qdcount[7:0]);
    push_random(6);
  endtask

  // Length byte then label body, mixing letters of both cases with any byte
  task automatic push_label(input int len);
    logic [BYTE_W-1:0] ch;
    msg_bytes.push_back(len[7:0]);
    repeat (len) begin
      case ($urandom_range(0, 3))
        0:       ch = CH_UPPER_A + BYTE_W'($urandom_range(0, 25));
        1:       ch = 8'h61 + BYTE_W'($urandom_range(0, 25));
        2:       ch = 8'h30 + BYTE_W'($urandom_range(0, 9));
        default: ch = BYTE_W'($urandom_range(0, 255));
      endcase
      msg_bytes.push_back(ch);
    end
  endtask

  task automatic build_random_message();
    msg_shape_t        shape;
    int                pick;
    int                nlab;
    int                cut;
    logic [15:0]       qd;
    logic [BYTE_W-1:0] flagged;
    msg_bytes.delete();
    pick  = $urandom_range(0, 99);
    shape = (pick < 45) ? MSG_GOOD :
            (pick < 55) ? MSG_ROOT :
            (pick < 68) ? MSG_TRUNC :
            (pick < 76) ? MSG_NO_QD :
            (pick < 86) ? MSG_COMPRESS :
            (pick < 94) ? MSG_LONG_LABELS : MSG_NOISE;
    if (shape == MSG_NOISE) begin
      push_random($urandom_range(1, 20));
    end else begin
      qd = 16'($urandom_range(1, 65535));
      if (shape == MSG_NO_QD) qd = '0;
      push_header(ID_W'($urandom_range(0, 65535)), qd);
      nlab = (shape == MSG_ROOT) ? 0 : $urandom_range(1, 4);
      for (int i = 0; i < nlab; i++) begin
        if (shape == MSG_COMPRESS && i == nlab - 1) begin
          // pointer or reserved label type in place of the last label
          flagged      = BYTE_W'($urandom_range(0, 255));
          flagged[7:6] = 2'($urandom_range(1, 3));
          msg_bytes.push_back(flagged);
        end else begin
          push_label(shape == MSG_LONG_LABELS ? $urandom_range(40, MAX_LABEL)
                                              : $urandom_range(1, 10));
        end
      end
      if (shape != MSG_COMPRESS) begin
        msg_bytes.push_back(8'h00);
        push_random(4);
      end
      // trailing records are ignored after the summary
      push_random($urandom_range(0, 6));
      if (shape == MSG_TRUNC) begin
        cut = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
    end
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    // a byte that makes no word may still be inside the block
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_name_limit(input logic [LIMIT_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limits_used++;
  endtask

  initial begin
    logic [BYTE_W-1:0]  name_tail[12];
    logic [LIMIT_W-1:0] limit_plan[9];
    int                 phase_start;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed messages at the reset limit
    // single byte: cut inside the ID
    msg_bytes.delete();
    msg_bytes.push_back(8'hFF);
    send_message();
    // zero question count, ends on the header's last byte plus two ignored bytes
    msg_bytes.delete();
    push_header(16'h0000, 16'h0000);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'h00);
    send_message();
    // letters at the case edges, a 0xff label, all-ones QTYPE; only QDCOUNT high set
    msg_bytes.delete();
    push_header(16'hFFFF, 16'h0100);
    name_tail = '{8'd4, CH_UPPER_A, CH_UPPER_Z, 8'h40, 8'h5B, 8'd1, 8'hFF, 8'h00,
                  8'hFF, 8'hFF, 8'h00, 8'h01};
    foreach (name_tail[i]) msg_bytes.push_back(name_tail[i]);
    send_message();
    // compression pointer as the first length byte, also the final byte
    msg_bytes.delete();
    push_header(16'h8001, 16'h0001);
    msg_bytes.push_back(8'hC0);
    send_message();

    // Random messages over a range of name limits, extremes included
    limit_plan    = '{11'd0, 11'd1, 11'd1024, 11'd3, 11'd2047, 11'd12, 11'd40, 11'd300,
                      11'd256};
    limit_plan[7] = LIMIT_W'($urandom_range(1, 2047));
    foreach (limit_plan[p]) begin
      set_name_limit(limit_plan[p]);
      // long output stall while bytes keep coming, so the input backs up
      if (limit_plan[p] == 11'd1024) hold_requests <= hold_requests + 1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_random_message();
        send_message();
      end
      // a full-length label sent into a long receiver hold fills the queue
      if (limit_plan[p] == 11'd2047) begin
        msg_bytes.delete();
        push_header(ID_W'($urandom_range(0, 65535)), 16'h0001);
        repeat (BIG_LABELS) push_label(MAX_LABEL);
        msg_bytes.push_back(8'h00);
        push_random(4);
        hold_requests <= hold_requests + 1;
        send_message();
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_for_drain();
    $display("Sent %0d message bytes in %0d messages under %0d name_limit settings.",
             bytes_sent, messages_sent, limits_used);
    $display("Checked %0d name characters and %0d summaries; status codes seen %b.",
             chars_seen, summaries_seen, status_mask);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/dqp_pkg.sv
design/dqp_front.sv
design/dqp_queue.sv
design/dqp_back.sv
design/dns_question_parser_top.sv
test/dns_question_parser_check.sv
test/dns_question_parser_top_test.sv
